// ----- hw/rtl/xmsd_pkg.sv -----
// ModRM / SIB / displacement decoder: shared types, field codes and helpers
// used by xmsd_decode and the top level x86_modrm_sib_decoder
// no dependencies
`default_nettype none

package xmsd_pkg;

    // addressing size codes
    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_32 = 2'd1;
    localparam logic [1:0] MODE_64 = 2'd2;
    localparam logic [1:0] MODE_RSV = 2'd3;

    // ModRM mod codes
    localparam logic [1:0] MOD_IND = 2'd0;
    localparam logic [1:0] MOD_D8  = 2'd1;
    localparam logic [1:0] MOD_D32 = 2'd2;
    localparam logic [1:0] MOD_REG = 2'd3;

    // special rm / base low-bit codes
    localparam logic [2:0] RM_SIB      = 3'd4;
    localparam logic [2:0] RM_DISP32   = 3'd5;
    localparam logic [3:0] RM16_DISP16 = 4'd6;

    // displacement lengths in bytes
    localparam logic [2:0] DLEN_NONE = 3'd0;
    localparam logic [2:0] DLEN_8    = 3'd1;
    localparam logic [2:0] DLEN_16   = 3'd2;
    localparam logic [2:0] DLEN_32   = 3'd4;

    // addressing form codes
    localparam logic [3:0] FORM_REG      = 4'd0;
    localparam logic [3:0] FORM_16_MOD0  = 4'd1;
    localparam logic [3:0] FORM_16_DISP  = 4'd2;
    localparam logic [3:0] FORM_32_MOD0  = 4'd3;
    localparam logic [3:0] FORM_64_MOD0  = 4'd7;
    localparam logic [3:0] FORM_OFS_DISP = 4'd1;
    localparam logic [3:0] FORM_OFS_SIB  = 4'd2;

    // decode phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIB,
        PH_DISP
    } t_phase;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
        logic [1:0] addr_mode;
        logic       ext_reg;
        logic       ext_index;
        logic       ext_base;
        logic       ctrl_reg_move;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [1:0]  mode_bits;
        logic [3:0]  reg_field;
        logic [3:0]  rm_field;
        logic        has_sib;
        logic [1:0]  scale_log;
        logic [3:0]  index_reg;
        logic [3:0]  base_reg;
        logic [31:0] displacement;
        logic [3:0]  address_form;
        logic [2:0]  byte_count;
    } t_out_beat;

    // result from the decode stage to the output stage
    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_res;

    // trim the gathered displacement to its length; an 8-bit one is sign-extended (to 16 bits in 16-bit mode)
    function automatic logic [31:0] disp_fix(input logic [31:0] acc,
                                             input logic [2:0]  len,
                                             input logic [1:0]  mode);
        logic [31:0] d;
        begin
            case (len)
                DLEN_NONE: d = 32'd0;
                DLEN_8: begin
                    if (mode == MODE_16)
                        d = {16'd0, {8{acc[7]}}, acc[7:0]};
                    else
                        d = {{24{acc[7]}}, acc[7:0]};
                end
                DLEN_16:   d = {16'd0, acc[15:0]};
                default:   d = acc;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/xmsd_decode.sv -----
// decode stage: holds the operand state and consumes one byte per accepted beat
// depends on xmsd_pkg
`default_nettype none

module xmsd_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire xmsd_pkg::t_in_beat i_beat,
    output xmsd_pkg::t_res         o_res
);

    xmsd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_rem, n_rem;
    logic [2:0]  r_len, n_len;
    logic [2:0]  r_bytes, n_bytes;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_mode, n_mode;
    logic        r_x, n_x;
    logic        r_b, n_b;
    logic [1:0]  r_mod, n_mod;
    logic [3:0]  r_reg, n_reg;
    logic [3:0]  r_rm, n_rm;
    logic        r_sib, n_sib;
    logic [1:0]  r_scale, n_scale;
    logic [3:0]  r_index, n_index;
    logic [3:0]  r_base, n_base;
    logic [3:0]  r_form, n_form;

    // next state and result for the byte on offer
    always_comb begin
        logic [7:0] b;
        logic [1:0] mode;
        logic       rr, xx, bb;
        logic [3:0] fbase;
        logic [3:0] sub;
        logic [3:0] base_full;
        logic [1:0] pos;
        logic       emit;

        b = i_beat.data_byte;
        mode = '0;
        rr = 1'b0;
        xx = 1'b0;
        bb = 1'b0;
        fbase = '0;
        sub = '0;
        base_full = '0;
        pos = '0;
        emit = 1'b0;

        n_phase = r_phase;
        n_rem   = r_rem;
        n_len   = r_len;
        n_bytes = r_bytes;
        n_acc   = r_acc;
        n_mode  = r_mode;
        n_x     = r_x;
        n_b     = r_b;
        n_mod   = r_mod;
        n_reg   = r_reg;
        n_rm    = r_rm;
        n_sib   = r_sib;
        n_scale = r_scale;
        n_index = r_index;
        n_base  = r_base;
        n_form  = r_form;

        if (i_take) begin
            if (i_beat.start_flag) begin
                // ModRM byte: restart the operand
                mode = (i_beat.addr_mode == xmsd_pkg::MODE_RSV) ? xmsd_pkg::MODE_64
                                                                 : i_beat.addr_mode;
                if (mode != xmsd_pkg::MODE_16) begin
                    rr = i_beat.ext_reg;
                    xx = i_beat.ext_index;
                    bb = i_beat.ext_base;
                end
                n_mode  = mode;
                n_x     = xx;
                n_b     = bb;
                n_mod   = i_beat.ctrl_reg_move ? xmsd_pkg::MOD_REG : b[7:6];
                n_reg   = {rr, b[5:3]};
                n_rm    = {bb, b[2:0]};
                n_sib   = 1'b0;
                n_scale = '0;
                n_index = '0;
                n_base  = '0;
                n_bytes = 3'd1;
                n_acc   = '0;
                n_rem   = '0;
                n_len   = xmsd_pkg::DLEN_NONE;
                n_form  = xmsd_pkg::FORM_REG;
                n_phase = xmsd_pkg::PH_IDLE;

                if (n_mod == xmsd_pkg::MOD_REG) begin
                    emit = 1'b1;
                end else if (mode == xmsd_pkg::MODE_16) begin
                    if (n_mod == xmsd_pkg::MOD_IND) begin
                        n_form = xmsd_pkg::FORM_16_MOD0;
                        n_len  = (n_rm == xmsd_pkg::RM16_DISP16) ? xmsd_pkg::DLEN_16
                                                                 : xmsd_pkg::DLEN_NONE;
                    end else begin
                        n_form = xmsd_pkg::FORM_16_DISP;
                        n_len  = (n_mod == xmsd_pkg::MOD_D8) ? xmsd_pkg::DLEN_8
                                                             : xmsd_pkg::DLEN_16;
                    end
                end else begin
                    fbase = (mode == xmsd_pkg::MODE_32) ? xmsd_pkg::FORM_32_MOD0
                                                        : xmsd_pkg::FORM_64_MOD0;
                    sub = (n_mod == xmsd_pkg::MOD_IND) ? 4'd0 : xmsd_pkg::FORM_OFS_DISP;
                    if (n_rm[2:0] == xmsd_pkg::RM_SIB) begin
                        n_form = fbase + xmsd_pkg::FORM_OFS_SIB + sub;
                    end else begin
                        n_form = fbase + sub;
                        if (n_mod == xmsd_pkg::MOD_IND)
                            n_len = (n_rm[2:0] == xmsd_pkg::RM_DISP32) ? xmsd_pkg::DLEN_32
                                                                       : xmsd_pkg::DLEN_NONE;
                        else
                            n_len = (n_mod == xmsd_pkg::MOD_D8) ? xmsd_pkg::DLEN_8
                                                                : xmsd_pkg::DLEN_32;
                    end
                end

                // memory form: SIB next, displacement next, or done
                if (n_mod != xmsd_pkg::MOD_REG) begin
                    if (mode != xmsd_pkg::MODE_16 && n_rm[2:0] == xmsd_pkg::RM_SIB) begin
                        n_phase = xmsd_pkg::PH_SIB;
                    end else if (n_len == xmsd_pkg::DLEN_NONE) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = xmsd_pkg::PH_DISP;
                        n_rem   = n_len;
                    end
                end
            end else begin
                unique case (r_phase)
                    xmsd_pkg::PH_SIB: begin
                        // SIB byte
                        base_full = {r_b, b[2:0]};
                        n_sib   = 1'b1;
                        n_scale = b[7:6];
                        n_index = {r_x, b[5:3]};
                        n_base  = base_full;
                        n_bytes = r_bytes + 3'd1;
                        n_acc   = '0;
                        if (r_mod == xmsd_pkg::MOD_IND)
                            n_len = (base_full[2:0] == xmsd_pkg::RM_DISP32)
                                    ? xmsd_pkg::DLEN_32 : xmsd_pkg::DLEN_NONE;
                        else
                            n_len = (r_mod == xmsd_pkg::MOD_D8) ? xmsd_pkg::DLEN_8
                                                                : xmsd_pkg::DLEN_32;
                        n_rem = n_len;
                        if (n_len == xmsd_pkg::DLEN_NONE)
                            emit = 1'b1;
                        else
                            n_phase = xmsd_pkg::PH_DISP;
                    end
                    xmsd_pkg::PH_DISP: begin
                        // displacement byte, little-endian
                        pos     = r_len[1:0] - r_rem[1:0];
                        n_acc   = r_acc | ({24'd0, b} << {pos, 3'b000});
                        n_bytes = r_bytes + 3'd1;
                        n_rem   = r_rem - 3'd1;
                        if (n_rem == 3'd0)
                            emit = 1'b1;
                    end
                    default: begin
                        // stray byte while idle is dropped
                    end
                endcase
            end

            if (emit) begin
                n_phase = xmsd_pkg::PH_IDLE;
                n_rem   = '0;
            end
        end

        // result beat
        o_res.valid             = emit;
        o_res.beat.mode_bits    = n_mod;
        o_res.beat.reg_field    = n_reg;
        o_res.beat.rm_field     = n_rm;
        o_res.beat.has_sib      = n_sib;
        o_res.beat.scale_log    = n_scale;
        o_res.beat.index_reg    = n_index;
        o_res.beat.base_reg     = n_base;
        o_res.beat.displacement = xmsd_pkg::disp_fix(n_acc, n_len, n_mode);
        o_res.beat.address_form = n_form;
        o_res.beat.byte_count   = n_bytes;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xmsd_pkg::PH_IDLE;
            r_rem   <= '0;
            r_bytes <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_bytes <= n_bytes;
        end
    end

    // operand fields
    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_acc   <= n_acc;
        r_mode  <= n_mode;
        r_x     <= n_x;
        r_b     <= n_b;
        r_mod   <= n_mod;
        r_reg   <= n_reg;
        r_rm    <= n_rm;
        r_sib   <= n_sib;
        r_scale <= n_scale;
        r_index <= n_index;
        r_base  <= n_base;
        r_form  <= n_form;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/x86_modrm_sib_decoder.sv -----
// top level of the ModRM / SIB / displacement decoder: decode stage plus
// registered output with a skid stage
// depends on xmsd_pkg and xmsd_decode
//
// Usage
//   Input channel: one instruction byte per beat on i_in_beat, qualified by
//   i_in_valid; the block holds it off with o_in_stall. A beat with
//   start_flag set is the ModRM byte and restarts decoding; the mode and
//   REX bits are sampled on that beat only. Unmarked bytes while idle are
//   dropped.
//   Output channel: one result beat on o_out_beat per operand, qualified by
//   o_out_valid, held while i_out_stall is high.
//   Throughput: one byte per cycle, sustained, as long as results drain.
//   Result: the result of an operand is registered when its last byte
//   (ModRM, SIB or final displacement byte) is accepted.
//   Stall: a result that meets a stalled output goes to a one-entry skid
//   stage; o_in_stall is high only while that stage is full.
//   Reset: synchronous, active low; decode goes idle, output is emptied.
`default_nettype none

module x86_modrm_sib_decoder (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire xmsd_pkg::t_in_beat  i_in_beat,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      xmsd_pkg::t_out_beat o_out_beat
);

    logic                r_out_valid;
    xmsd_pkg::t_out_beat r_out;
    logic                r_skid_valid;
    xmsd_pkg::t_out_beat r_skid;
    logic                take;
    xmsd_pkg::t_res      res;

    // input beat accepted
    assign take = i_in_valid && !r_skid_valid;

    xmsd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_beat  (i_in_beat),
        .o_res   (res)
    );

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res.valid;
            end
        end else if (res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (res.valid)
                r_out <= res.beat;
        end else if (res.valid) begin
            r_skid <= res.beat;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

// ----- bench/tb_x86_modrm_sib_decoder.sv -----
// testbench for x86_modrm_sib_decoder: directed and random ModRM / SIB /
// displacement byte streams checked against a behavioural decoder model
// depends on xmsd_pkg and the x86_modrm_sib_decoder RTL

module tb_x86_modrm_sib_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import xmsd_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    x86_modrm_sib_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // decoder model state
    t_phase      dec_phase = PH_IDLE;
    logic [2:0]  dec_len   = '0;
    logic [2:0]  dec_left  = '0;
    logic [31:0] dec_acc   = '0;
    logic [1:0]  dec_mode  = MODE_16;
    logic        dec_x     = 1'b0;
    logic        dec_b     = 1'b0;
    t_out_beat   dec_op    = '0;
    t_out_beat   expected_ops[$];

    int mismatches   = 0;
    int results_seen = 0;
    int sib_results  = 0;
    int bytes_used   = 0;
    int stall_cycles = 0;
    int hold_cycles  = 0;
    int stall_left   = 0;
    bit tx_gaps      = 1'b0;
    bit rx_gaps      = 1'b0;

    // displacement length of a 32/64-bit memory form
    function automatic logic [2:0] disp_len32(input logic [1:0] md, input logic [2:0] low);
        if (md == MOD_IND)
            return (low == RM_DISP32) ? DLEN_32 : DLEN_NONE;
        return (md == MOD_D8) ? DLEN_8 : DLEN_32;
    endfunction

    // close the operand: trim the displacement and queue the result
    task automatic finish_operand();
        logic [31:0] d;
        case (dec_len)
            DLEN_NONE: d = '0;
            DLEN_8: begin
                if (dec_mode == MODE_16)
                    d = {16'd0, {8{dec_acc[7]}}, dec_acc[7:0]};
                else
                    d = {{24{dec_acc[7]}}, dec_acc[7:0]};
            end
            DLEN_16: d = {16'd0, dec_acc[15:0]};
            default: d = dec_acc;
        endcase
        dec_op.displacement = d;
        expected_ops.push_back(dec_op);
        dec_phase = PH_IDLE;
        dec_left  = '0;
    endtask

    // start gathering displacement, or close at once when there is none
    task automatic open_disp(input logic [2:0] len);
        dec_len  = len;
        dec_acc  = '0;
        dec_left = len;
        if (len == DLEN_NONE)
            finish_operand();
        else
            dec_phase = PH_DISP;
    endtask

    // advance the model by one accepted byte
    task automatic decode_byte(input t_in_beat b);
        logic [1:0] md;
        logic       r;
        logic [3:0] rm;
        logic [3:0] fbase;
        logic [2:0] pos;
        if (b.start_flag) begin
            dec_mode = (b.addr_mode == MODE_RSV) ? MODE_64 : b.addr_mode;
            // REX bits mean nothing in 16-bit addressing
            r     = (dec_mode == MODE_16) ? 1'b0 : b.ext_reg;
            dec_x = (dec_mode == MODE_16) ? 1'b0 : b.ext_index;
            dec_b = (dec_mode == MODE_16) ? 1'b0 : b.ext_base;
            md    = b.ctrl_reg_move ? MOD_REG : b.data_byte[7:6];
            rm    = {dec_b, b.data_byte[2:0]};
            dec_op            = '0;
            dec_op.mode_bits  = md;
            dec_op.reg_field  = {r, b.data_byte[5:3]};
            dec_op.rm_field   = rm;
            dec_op.byte_count = 3'd1;
            dec_len  = DLEN_NONE;
            dec_acc  = '0;
            dec_left = '0;
            if (md == MOD_REG) begin
                dec_op.address_form = FORM_REG;
                finish_operand();
            end else if (dec_mode == MODE_16) begin
                if (md == MOD_IND) begin
                    dec_op.address_form = FORM_16_MOD0;
                    open_disp((rm == RM16_DISP16) ? DLEN_16 : DLEN_NONE);
                end else begin
                    dec_op.address_form = FORM_16_DISP;
                    open_disp((md == MOD_D8) ? DLEN_8 : DLEN_16);
                end
            end else begin
                fbase = (dec_mode == MODE_32) ? FORM_32_MOD0 : FORM_64_MOD0;
                if (md != MOD_IND)
                    fbase = fbase + FORM_OFS_DISP;
                if (rm[2:0] == RM_SIB) begin
                    dec_op.address_form = fbase + FORM_OFS_SIB;
                    dec_phase = PH_SIB;
                end else begin
                    dec_op.address_form = fbase;
                    open_disp(disp_len32(md, rm[2:0]));
                end
            end
        end else if (dec_phase == PH_SIB) begin
            dec_op.has_sib    = 1'b1;
            dec_op.scale_log  = b.data_byte[7:6];
            dec_op.index_reg  = {dec_x, b.data_byte[5:3]};
            dec_op.base_reg   = {dec_b, b.data_byte[2:0]};
            dec_op.byte_count = dec_op.byte_count + 3'd1;
            open_disp(disp_len32(dec_op.mode_bits, b.data_byte[2:0]));
        end else if (dec_phase == PH_DISP) begin
            // little-endian gather
            pos     = dec_len - dec_left;
            dec_acc = dec_acc | (32'(b.data_byte) << (8 * pos[1:0]));
            dec_op.byte_count = dec_op.byte_count + 3'd1;
            dec_left = dec_left - 3'd1;
            if (dec_left == 3'd0)
                finish_operand();
        end
    endtask

    function automatic t_in_beat head_byte(input logic [7:0] modrm, input logic [1:0] mode,
                                           input logic [2:0] rxb, input logic ctl);
        t_in_beat h;
        h.data_byte     = modrm;
        h.start_flag    = 1'b1;
        h.addr_mode     = mode;
        {h.ext_reg, h.ext_index, h.ext_base} = rxb;
        h.ctrl_reg_move = ctl;
        return h;
    endfunction

    // unmarked byte; the side fields are don't-care and get random values
    function automatic t_in_beat follow_byte(input logic [7:0] d);
        t_in_beat f;
        f.data_byte  = d;
        f.start_flag = 1'b0;
        {f.addr_mode, f.ext_reg, f.ext_index, f.ext_base, f.ctrl_reg_move} = 6'($urandom);
        return f;
    endfunction

    function automatic t_in_beat random_head();
        return head_byte(8'($urandom), 2'($urandom), 3'($urandom),
                         $urandom_range(0, 7) == 0);
    endfunction

    // offer one beat, optionally after a random gap, and wait for acceptance
    task automatic send_byte(input t_in_beat b);
        int n;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        if (b.start_flag || dec_phase != PH_IDLE)
            bytes_used++;
        decode_byte(b);
    endtask

    // ModRM beat then whatever SIB / displacement beats the model still wants;
    // keep >= 0 cuts the operand short after that many follow-on beats
    task automatic send_operand(input t_in_beat h, input logic [7:0] sib,
                                input logic [31:0] disp, input int keep);
        int         k;
        logic [2:0] pos;
        k = 0;
        send_byte(h);
        while (dec_phase != PH_IDLE && k != keep) begin
            if (dec_phase == PH_SIB) begin
                send_byte(follow_byte(sib));
            end else begin
                pos = dec_len - dec_left;
                send_byte(follow_byte(disp[8 * pos[1:0] +: 8]));
            end
            k++;
        end
    endtask

    // sender stops until every pending result has drained
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_ops.size() != 0) @(posedge clk);
    endtask

    task automatic test_register_forms();
        send_operand(head_byte(8'hFF, MODE_16, 3'b111, 1'b0), 8'h00, 32'h0, -1);
        send_operand(head_byte(8'hC0, MODE_64, 3'b101, 1'b0), 8'h00, 32'h0, -1);
        // control register move turns a memory byte into register form
        send_operand(head_byte(8'h00, MODE_32, 3'b000, 1'b1), 8'h00, 32'h0, -1);
        send_operand(head_byte(8'hE5, MODE_RSV, 3'b111, 1'b1), 8'h00, 32'h0, -1);
    endtask

    task automatic test_16bit_memory();
        // direct 16-bit address, REX bits set but ignored
        send_operand(head_byte(8'h06, MODE_16, 3'b111, 1'b0), 8'h00, 32'h1234, -1);
        // negative 8-bit displacement extends to 16 bits only
        send_operand(head_byte(8'h47, MODE_16, 3'b000, 1'b0), 8'h00, 32'h80, -1);
    endtask

    task automatic test_32_64_memory();
        send_operand(head_byte(8'h05, MODE_32, 3'b000, 1'b0), 8'h00, 32'hDEADBEEF, -1);
        // SIB with base 5 under mod 0 pulls in a 32-bit displacement
        send_operand(head_byte(8'h04, MODE_64, 3'b111, 1'b0), 8'h25, 32'h80000000, -1);
        // reserved mode behaves as 64-bit
        send_operand(head_byte(8'h44, MODE_RSV, 3'b011, 1'b0), 8'hFF, 32'h80, -1);
    endtask

    task automatic test_restart();
        // stray byte while idle, then a decode cut short by a new ModRM
        send_byte(follow_byte(8'hA5));
        send_operand(head_byte(8'h84, MODE_32, 3'b010, 1'b0), 8'h00, 32'h55667788, 2);
        send_operand(head_byte(8'hC1, MODE_32, 3'b000, 1'b0), 8'h00, 32'h0, -1);
    endtask

    task automatic test_random_operands(input int n);
        int target;
        int pick;
        target = bytes_used + n;
        while (bytes_used < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                send_operand(random_head(), 8'($urandom), $urandom, -1);
            else if (pick < 92)
                send_byte(follow_byte(8'($urandom)));
            else
                send_operand(random_head(), 8'($urandom), $urandom, $urandom_range(0, 3));
        end
    endtask

    // receiver holds off while register-form operands keep coming
    task automatic test_backpressure();
        hold_cycles = 80;
        repeat (30)
            send_operand(head_byte({2'b11, 6'($urandom)}, 2'($urandom), 3'($urandom), 1'b0),
                         8'h00, 32'h0, -1);
        drain_results();
    endtask

    // receiver stall: long hold-off on request, else random bursts
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles--;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 11);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t, result %0d: %s expected %0h got %0h",
                     $realtime, results_seen, what, exp_v, got_v);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
            note_mismatch(what, exp_v, got_v);
    endtask

    // result beat check against the oldest pending operand
    always @(posedge clk) begin
        t_out_beat e;
        if (rst_n && in_valid && in_stall)
            stall_cycles++;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_ops.size() == 0) begin
                note_mismatch("result with nothing pending, form", 32'd0,
                              32'(out_beat.address_form));
            end else begin
                e = expected_ops.pop_front();
                check_field("mode_bits", 32'(e.mode_bits), 32'(out_beat.mode_bits));
                check_field("reg_field", 32'(e.reg_field), 32'(out_beat.reg_field));
                check_field("rm_field", 32'(e.rm_field), 32'(out_beat.rm_field));
                check_field("has_sib", 32'(e.has_sib), 32'(out_beat.has_sib));
                check_field("scale_log", 32'(e.scale_log), 32'(out_beat.scale_log));
                check_field("index_reg", 32'(e.index_reg), 32'(out_beat.index_reg));
                check_field("base_reg", 32'(e.base_reg), 32'(out_beat.base_reg));
                check_field("displacement", e.displacement, out_beat.displacement);
                check_field("address_form", 32'(e.address_form), 32'(out_beat.address_form));
                check_field("byte_count", 32'(e.byte_count), 32'(out_beat.byte_count));
                if (e.has_sib)
                    sib_results++;
            end
            results_seen++;
        end
    end

    // test sequence
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_forms();
        test_16bit_memory();
        test_32_64_memory();
        test_restart();

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_random_operands(240);
        test_backpressure();

        // closing stretch at full rate
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random_operands(100);

        drain_results();
        repeat (20) @(posedge clk);

        $display("decoded %0d bytes into %0d results, %0d of them with a SIB byte",
                 bytes_used, results_seen, sib_results);
        $display("input held off for %0d cycles, %0d mismatches", stall_cycles, mismatches);
        if (mismatches == 0 && expected_ops.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #1ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
